>>> rtl/c2d_pkg.sv
// Shared types and constants for the 2D convolution stream engine.
`default_nettype none
package c2d_pkg;
  localparam logic [1:0] CMD_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_BIAS    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;
  localparam logic [1:0] CMD_RESTART = 2'd3;

  localparam logic [2:0] REG_HEIGHT = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_KERNEL = 3'd2;
  localparam logic [2:0] REG_STEP   = 3'd3;
  localparam logic [2:0] REG_INPL   = 3'd4;
  localparam logic [2:0] REG_OUTPL  = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BIAS  = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_EMIT  = 6'b010000,
    ST_NEXT  = 6'b100000
  } state_e;

  typedef struct packed {
    logic start_ch;
    logic mac_en;
    logic emit;
    logic advance;
    logic take;
  } ctrl_t;

  typedef struct packed {
    logic fire;
    logic mac_done;
    logic acc_busy;
    logic out_free;
    logic ch_last;
  } stat_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

>>> rtl/conv2d_stream_engine.sv
// Top level of the streaming multichannel 2D convolution engine.
// Usage:
//   s_axis carries commands: load weight, load bias, sample, restart frame.
//   Samples arrive in raster order with the input plane varying fastest.
//   cfg writes set registers 0..5 (height, width, kernel, stride, in/out planes);
//   the user must make them only while the engine is idle; the block does not enforce this.
//   A sample that completes a stride-aligned window produces one word per
//   output plane on m_axis, in plane order; tlast marks the final plane.
// Timing:
//   Loads, restart and non-completing samples are accepted without leaving the idle state.
//   A completing sample holds off further input while the single shared
//   multiply-accumulate unit steps over the window for each output plane.
//   Each result sits in an output register; a stall on m_axis holds the
//   sequencer before the next plane.
// Reset:
//   Positions and phases clear, registers return to 28x28, k=3, stride 1,
//   one input plane, sixteen output planes. Coefficient and line stores are
//   not cleared and must be loaded before use.
`default_nettype none
module conv2d_stream_engine #(
  parameter int MAX_WIDTH      = 64,
  parameter int MAX_KERNEL     = 5,
  parameter int MAX_IN_PLANES  = 4,
  parameter int MAX_OUT_PLANES = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // command[1:0], coef_index[12:2], data_word[44:13]
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // out_plane[3:0], out_row[9:4], out_col[15:10],
                                      // out_value[47:16]
  output logic        m_axis_tlast,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i
);
  logic [6:0] h_q, w_q;
  logic [2:0] k_q, s_q, ip_q;
  logic [4:0] op_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= 7'd28; w_q <= 7'd28; k_q <= 3'd3; s_q <= 3'd1; ip_q <= 3'd1; op_q <= 5'd16;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        c2d_pkg::REG_HEIGHT: h_q  <= cfg_data_i[6:0];
        c2d_pkg::REG_WIDTH:  w_q  <= cfg_data_i[6:0];
        c2d_pkg::REG_KERNEL: k_q  <= cfg_data_i[2:0];
        c2d_pkg::REG_STEP:   s_q  <= cfg_data_i[2:0];
        c2d_pkg::REG_INPL:   ip_q <= cfg_data_i[2:0];
        c2d_pkg::REG_OUTPL:  op_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  c2d_pkg::ctrl_t ctrl;
  c2d_pkg::stat_t stat;

  c2d_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .stat_i(stat), .ctrl_o(ctrl),
    .in_ready_o(s_axis_tready)
  );

  c2d_dp #(
    .MaxWidth(MAX_WIDTH), .MaxKernel(MAX_KERNEL),
    .MaxInPlanes(MAX_IN_PLANES), .MaxOutPlanes(MAX_OUT_PLANES)
  ) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .cmd_i(s_axis_tdata[1:0]), .idx_i(s_axis_tdata[12:2]), .data_i(s_axis_tdata[44:13]),
    .h_i(h_q), .w_i(w_q), .k_i(k_q), .s_i(s_q), .ip_i(ip_q), .op_i(op_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_plane_o(m_axis_tdata[3:0]), .out_row_o(m_axis_tdata[9:4]),
    .out_col_o(m_axis_tdata[15:10]), .out_value_o(m_axis_tdata[47:16]),
    .out_last_o(m_axis_tlast)
  );

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !ctrl.emit)
    else $error("emit while output blocked");
  a_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && stat.fire |=> !s_axis_tready)
    else $error("accepted during window");
`endif
endmodule
`default_nettype wire

>>> rtl/c2d_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module c2d_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(Depth)-1:0] waddr_i,
  input  wire [Width-1:0]         wdata_i,
  input  wire [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]        rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/c2d_ctrl.sv
// Sequencer for the convolution engine.
`default_nettype none
module c2d_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire c2d_pkg::stat_t stat_i,
  output c2d_pkg::ctrl_t      ctrl_o,
  output logic                in_ready_o
);
  c2d_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      c2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.take = 1'b1;
          if (stat_i.fire) state_d = c2d_pkg::ST_BIAS;
        end
      end
      c2d_pkg::ST_BIAS: begin
        ctrl_o.start_ch = 1'b1;
        state_d = c2d_pkg::ST_MAC;
      end
      c2d_pkg::ST_MAC: begin
        ctrl_o.mac_en = 1'b1;
        if (stat_i.mac_done) state_d = c2d_pkg::ST_DRAIN;
      end
      c2d_pkg::ST_DRAIN: begin
        state_d = c2d_pkg::ST_EMIT;
      end
      c2d_pkg::ST_EMIT: begin
        if (stat_i.out_free && !stat_i.acc_busy) begin
          ctrl_o.emit = 1'b1;
          state_d = stat_i.ch_last ? c2d_pkg::ST_NEXT : c2d_pkg::ST_BIAS;
        end
      end
      c2d_pkg::ST_NEXT: begin
        ctrl_o.advance = 1'b1;
        state_d = c2d_pkg::ST_IDLE;
      end
      default: state_d = c2d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= c2d_pkg::ST_IDLE;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

>>> rtl/c2d_dp.sv
// Datapath: stores, position tracking, multiply-accumulate and output register.
`default_nettype none
module c2d_dp #(
  parameter int MaxWidth     = 64,
  parameter int MaxKernel    = 5,
  parameter int MaxInPlanes  = 4,
  parameter int MaxOutPlanes = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire c2d_pkg::ctrl_t ctrl_i,
  output c2d_pkg::stat_t      stat_o,
  input  wire [1:0]      cmd_i,
  input  wire [10:0]     idx_i,
  input  wire [31:0]     data_i,
  input  wire [6:0]      h_i,
  input  wire [6:0]      w_i,
  input  wire [2:0]      k_i,
  input  wire [2:0]      s_i,
  input  wire [2:0]      ip_i,
  input  wire [4:0]      op_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output logic [3:0]     out_plane_o,
  output logic [5:0]     out_row_o,
  output logic [5:0]     out_col_o,
  output logic [31:0]    out_value_o,
  output logic           out_last_o
);
  localparam int LineDepth = MaxKernel * MaxWidth * MaxInPlanes;
  localparam int WDepth    = MaxOutPlanes * MaxInPlanes * MaxKernel * MaxKernel;
  localparam int LaW = $clog2(LineDepth);
  localparam int WaW = $clog2(WDepth);
  localparam int CW  = $clog2(MaxWidth + 1);
  localparam int KW  = $clog2(MaxKernel + 1);
  localparam int IW  = $clog2(MaxInPlanes + 1);
  localparam int OW  = $clog2(MaxOutPlanes + 1);
  localparam int KrW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1;
  localparam int XW  = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int PW  = (MaxInPlanes > 1) ? $clog2(MaxInPlanes) : 1;
  localparam int BaW = (MaxOutPlanes > 1) ? $clog2(MaxOutPlanes) : 1;

  // clamped configuration
  logic [CW-1:0] h, w;
  logic [KW-1:0] k;
  logic [2:0]    s;
  logic [IW-1:0] ip;
  logic [OW-1:0] op;
  always_comb begin
    h  = (h_i == 0) ? CW'(1) : (32'(h_i) > MaxWidth) ? CW'(MaxWidth) : CW'(h_i);
    w  = (w_i == 0) ? CW'(1) : (32'(w_i) > MaxWidth) ? CW'(MaxWidth) : CW'(w_i);
    k  = (k_i == 0) ? KW'(1) : (32'(k_i) > MaxKernel) ? KW'(MaxKernel) : KW'(k_i);
    s  = (s_i == 0) ? 3'd1 : (s_i > 3'd4) ? 3'd4 : s_i;
    ip = (ip_i == 0) ? IW'(1) : (32'(ip_i) > MaxInPlanes) ? IW'(MaxInPlanes) : IW'(ip_i);
    op = (op_i == 0) ? OW'(1) : (32'(op_i) > MaxOutPlanes) ? OW'(MaxOutPlanes) : OW'(op_i);
  end

  logic [CW-1:0] row_q, col_q;
  logic [IW-1:0] pl_q;
  logic [1:0]    rph_q, cph_q;
  logic [KrW-1:0] rmod_q;

  logic is_sample, plane_last, win;
  assign is_sample  = ctrl_i.take && cmd_i == c2d_pkg::CMD_SAMPLE;
  assign plane_last = 32'(pl_q) + 1 >= 32'(ip);
  assign win = 32'(row_q) + 1 >= 32'(k) && 32'(col_q) + 1 >= 32'(k)
               && rph_q == 2'd0 && cph_q == 2'd0;
  assign stat_o.fire = is_sample && plane_last && win;

  // line store address: (row % K * W + col) * P + plane
  function automatic logic [LaW-1:0] laddr(input logic [KrW-1:0] r,
                                            input logic [CW-1:0] c,
                                            input logic [IW-1:0] p);
    return LaW'((32'(r) * MaxWidth + 32'(c[XW-1:0] % MaxWidth)) * MaxInPlanes
                + 32'(p) % MaxInPlanes);
  endfunction

  logic [LaW-1:0] lraddr;
  logic [15:0]    lrdata;
  c2d_ram #(.Width(16), .Depth(LineDepth)) u_line (
    .clk_i, .we_i(is_sample), .waddr_i(laddr(rmod_q, col_q, pl_q)),
    .wdata_i(c2d_pkg::sat16(data_i)), .raddr_i(lraddr), .rdata_o(lrdata)
  );

  logic [WaW-1:0] wraddr;
  logic [15:0]    wrdata;
  logic           wwe;
  assign wwe = ctrl_i.take && cmd_i == c2d_pkg::CMD_WEIGHT && 32'(idx_i) < WDepth;
  c2d_ram #(.Width(16), .Depth(WDepth)) u_wt (
    .clk_i, .we_i(wwe), .waddr_i(WaW'(idx_i)), .wdata_i(c2d_pkg::sat16(data_i)),
    .raddr_i(wraddr), .rdata_o(wrdata)
  );

  logic [31:0] bias_q [MaxOutPlanes];
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take && cmd_i == c2d_pkg::CMD_BIAS && 32'(idx_i) < MaxOutPlanes)
      bias_q[BaW'(idx_i)] <= data_i;
  end

  // window walk
  logic [CW-1:0]  c0_q;
  logic [KrW-1:0] r0m_q, khm_q;
  logic [OW-1:0]  oc_q;
  logic [IW-1:0]  ic_q;
  logic [KW-1:0]  kh_q, kw_q;
  logic [WaW-1:0] wi_q;
  logic           pv_q, pv2_q;
  logic signed [31:0] prod_q;
  logic signed [47:0] acc_q;
  logic [5:0] orow_q, ocol_q;

  logic walk_end;
  assign walk_end = 32'(kw_q) + 1 >= 32'(k) && 32'(kh_q) + 1 >= 32'(k)
                    && 32'(ic_q) + 1 >= 32'(ip);
  assign stat_o.mac_done = ctrl_i.mac_en && walk_end;
  assign stat_o.acc_busy = pv_q || pv2_q;
  assign stat_o.ch_last  = 32'(oc_q) + 1 >= 32'(op);
  assign lraddr = laddr(khm_q, c0_q + CW'(kw_q), ic_q);
  assign wraddr = wi_q;

  logic [CW-1:0] r0n, c0n;
  assign r0n = row_q + 1 - CW'(k);
  assign c0n = col_q + 1 - CW'(k);

  // output divide by stride through shifts and a reciprocal multiplication
  logic [5:0] qr, qc;
  always_comb begin
    qr = '0; qc = '0;
    case (s)
      3'd1: begin qr = 6'(r0n); qc = 6'(c0n); end
      3'd2: begin qr = 6'(r0n >> 1); qc = 6'(c0n >> 1); end
      3'd3: begin qr = 6'((32'(r0n) * 171) >> 9); qc = 6'((32'(c0n) * 171) >> 9); end
      3'd4: begin qr = 6'(r0n >> 2); qc = 6'(c0n >> 2); end
      default: begin qr = '0; qc = '0; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0; col_q <= '0; pl_q <= '0; rph_q <= '0; cph_q <= '0; rmod_q <= '0;
      oc_q <= '0; pv_q <= 1'b0; pv2_q <= 1'b0; out_valid_o <= 1'b0;
    end else begin
      pv_q  <= ctrl_i.mac_en;
      pv2_q <= pv_q;
      if (ctrl_i.emit) out_valid_o <= 1'b1;
      else if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (ctrl_i.take && cmd_i == c2d_pkg::CMD_RESTART) begin
        row_q <= '0; col_q <= '0; pl_q <= '0; rph_q <= '0; cph_q <= '0; rmod_q <= '0;
      end
      if (stat_o.fire) oc_q <= '0;
      else if (ctrl_i.emit) oc_q <= oc_q + 1'b1;
      if (is_sample && !plane_last) pl_q <= pl_q + 1'b1;
      if ((is_sample && plane_last && !win) || ctrl_i.advance) begin
        pl_q <= '0;
        if (32'(col_q) + 1 < 32'(w)) begin
          col_q <= col_q + 1'b1;
          if (32'(col_q) + 1 >= 32'(k))
            cph_q <= (32'(cph_q) + 1 >= 32'(s)) ? 2'd0 : cph_q + 1'b1;
          else cph_q <= '0;
        end else begin
          col_q <= '0; cph_q <= '0;
          if (32'(row_q) + 1 < 32'(h)) begin
            row_q <= row_q + 1'b1;
            rmod_q <= (32'(rmod_q) + 1 >= MaxKernel) ? '0 : rmod_q + 1'b1;
            if (32'(row_q) + 1 >= 32'(k))
              rph_q <= (32'(rph_q) + 1 >= 32'(s)) ? 2'd0 : rph_q + 1'b1;
            else rph_q <= '0;
          end else begin
            row_q <= '0; rph_q <= '0; rmod_q <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat_o.fire) begin
      c0_q <= c0n; orow_q <= qr; ocol_q <= qc;
      r0m_q <= (32'(rmod_q) + 1 >= 32'(k)) ? KrW'(32'(rmod_q) + 1 - 32'(k)) :
               KrW'(32'(rmod_q) + MaxKernel + 1 - 32'(k));
      wi_q <= '0;
    end
    if (ctrl_i.start_ch) begin
      ic_q <= '0; kh_q <= '0; kw_q <= '0; khm_q <= r0m_q;
      acc_q <= 48'(signed'(bias_q[BaW'(oc_q)]));
    end
    if (ctrl_i.mac_en) begin
      wi_q <= wi_q + 1'b1;
      if (32'(kw_q) + 1 < 32'(k)) kw_q <= kw_q + 1'b1;
      else begin
        kw_q <= '0;
        if (32'(kh_q) + 1 < 32'(k)) begin
          kh_q <= kh_q + 1'b1;
          khm_q <= (32'(khm_q) + 1 >= MaxKernel) ? '0 : khm_q + 1'b1;
        end else begin
          kh_q <= '0; khm_q <= r0m_q; ic_q <= ic_q + 1'b1;
        end
      end
    end
    if (pv_q) prod_q <= signed'(lrdata) * signed'(wrdata);
    if (pv2_q) acc_q <= acc_q + 48'(prod_q);
    if (ctrl_i.emit) begin
      out_plane_o <= 4'(oc_q);
      out_row_o <= orow_q;
      out_col_o <= ocol_q;
      out_last_o <= stat_o.ch_last;
      out_value_o <= (acc_q > 48'sd2147483647) ? 32'h7fffffff :
                     (acc_q < -48'sd2147483648) ? 32'h80000000 : acc_q[31:0];
    end
  end
  assign stat_o.out_free = !out_valid_o || out_ready_i;
endmodule
`default_nettype wire

>>> bench/tb_conv2d_stream_engine.sv
// Self-checking testbench for the streaming multichannel 2D convolution engine.
`timescale 1ns / 1ps
module tb_conv2d_stream_engine;

  typedef struct {
    logic [1:0]  cmd;
    logic [10:0] idx;
    logic [31:0] data;
  } word_t;

  typedef struct {
    logic [3:0]         plane;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] value;
    logic               last;
  } conv_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  conv2d_stream_engine uut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  word_t     stim_q[$];
  conv_out_t window_q[$];

  logic [6:0] r_height, r_width;
  logic [2:0] r_kernel, r_step, r_inpl;
  logic [4:0] r_outpl;
  logic signed [15:0] weight_mem [0:1599];
  logic signed [31:0] bias_mem [0:15];
  logic signed [15:0] line_mem [0:1279];
  int unsigned row_pos, col_pos, plane_pos, row_phase, col_phase;

  int errors = 0, n_words = 0, n_results = 0, n_windows = 0, n_cfg = 0, n_rand = 0;
  logic taken = 1'b0;
  int burst_left = 1, gap_left = 0;
  int hold_left = 0, stall_tick = 0;
  bit held_once = 1'b0;

  initial forever #5 clk_i = ~clk_i;

  function automatic int unsigned clampv(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [15:0] clip16(logic signed [31:0] v);
    if (v > 32'sd32767) return 16'sh7fff;
    if (v < -32'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic int unsigned line_addr(int unsigned r, int unsigned c, int unsigned p);
    return ((r % 5) * 64 + (c % 64)) * 4 + (p % 4);
  endfunction

  function automatic void convolve_word(word_t wd);
    int unsigned h, w, k, s, ip, op, r0, c0, wi;
    longint acc;
    conv_out_t e;
    h  = clampv(r_height, 64);
    w  = clampv(r_width, 64);
    k  = clampv(r_kernel, 5);
    s  = clampv(r_step, 4);
    ip = clampv(r_inpl, 4);
    op = clampv(r_outpl, 16);
    case (wd.cmd)
      c2d_pkg::CMD_WEIGHT: begin
        if (wd.idx < 1600) weight_mem[wd.idx] = clip16(wd.data);
        return;
      end
      c2d_pkg::CMD_BIAS: begin
        if (wd.idx < 16) bias_mem[wd.idx] = wd.data;
        return;
      end
      c2d_pkg::CMD_RESTART: begin
        row_pos = 0; col_pos = 0; plane_pos = 0; row_phase = 0; col_phase = 0;
        return;
      end
      default: ;
    endcase
    line_mem[line_addr(row_pos, col_pos, plane_pos)] = clip16(wd.data);
    if (plane_pos + 1 < ip) begin
      plane_pos++;
      return;
    end
    if (row_pos + 1 >= k && col_pos + 1 >= k && row_phase == 0 && col_phase == 0) begin
      r0 = row_pos + 1 - k;
      c0 = col_pos + 1 - k;
      n_windows++;
      for (int unsigned oc = 0; oc < op; oc++) begin
        acc = longint'(bias_mem[oc]);
        for (int unsigned ic = 0; ic < ip; ic++)
          for (int unsigned kh = 0; kh < k; kh++)
            for (int unsigned kw = 0; kw < k; kw++) begin
              wi = ((oc * ip + ic) * k + kh) * k + kw;
              acc += longint'(line_mem[line_addr(r0 + kh, c0 + kw, ic)])
                     * longint'(weight_mem[wi % 1600]);
            end
        if (acc > 64'sd2147483647) acc = 64'sd2147483647;
        if (acc < -64'sd2147483648) acc = -64'sd2147483648;
        e.plane = oc[3:0];
        e.row   = 6'((r0 / s) & 63);
        e.col   = 6'((c0 / s) & 63);
        e.value = acc[31:0];
        e.last  = (oc + 1 == op);
        window_q.insert(window_q.size(), e);
      end
    end
    plane_pos = 0;
    if (col_pos + 1 < w) begin
      col_pos++;
      if (col_pos >= k) col_phase = (col_phase + 1 >= s) ? 0 : col_phase + 1;
      else col_phase = 0;
    end else begin
      col_pos = 0;
      col_phase = 0;
      if (row_pos + 1 < h) begin
        row_pos++;
        if (row_pos >= k) row_phase = (row_phase + 1 >= s) ? 0 : row_phase + 1;
        else row_phase = 0;
      end else begin
        row_pos = 0;
        row_phase = 0;
      end
    end
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_word(logic [1:0] c, int unsigned i, logic [31:0] d);
    word_t wd;
    wd.cmd = c;
    wd.idx = i[10:0];
    wd.data = d;
    stim_q.insert(stim_q.size(), wd);
  endtask

  task automatic write_reg(logic [2:0] index, int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      c2d_pkg::REG_HEIGHT: r_height = value[6:0];
      c2d_pkg::REG_WIDTH:  r_width  = value[6:0];
      c2d_pkg::REG_KERNEL: r_kernel = value[2:0];
      c2d_pkg::REG_STEP:   r_step   = value[2:0];
      c2d_pkg::REG_INPL:   r_inpl   = value[2:0];
      c2d_pkg::REG_OUTPL:  r_outpl  = value[4:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_shape(int unsigned h, int unsigned w, int unsigned k,
                           int unsigned s, int unsigned ip, int unsigned op);
    write_reg(c2d_pkg::REG_HEIGHT, h);
    write_reg(c2d_pkg::REG_WIDTH, w);
    write_reg(c2d_pkg::REG_KERNEL, k);
    write_reg(c2d_pkg::REG_STEP, s);
    write_reg(c2d_pkg::REG_INPL, ip);
    write_reg(c2d_pkg::REG_OUTPL, op);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (stim_q.size() != 0 || s_axis_tvalid);
    while (window_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0: return r;
      1: return $urandom_range(0, 4095) - 2048;
      default: return {{16{r[15]}}, r[15:0]};
    endcase
  endfunction

  task automatic run_frames(int unsigned h, int unsigned w, int unsigned k,
                            int unsigned s, int unsigned ip, int unsigned op);
    int unsigned n;
    set_shape(h, w, k, s, ip, op);
    push_word(c2d_pkg::CMD_RESTART, $urandom_range(0, 2047), $urandom);
    n = clampv(r_height, 64) * clampv(r_width, 64) * clampv(r_inpl, 4) * $urandom_range(1, 2);
    if (n > 24) n = $urandom_range(8, 24);
    for (int unsigned i = 0; i < n; i++) begin
      case ($urandom_range(0, 39))
        0, 1: push_word(c2d_pkg::CMD_WEIGHT, $urandom_range(0, 2047), $urandom);
        2:    push_word(c2d_pkg::CMD_BIAS, $urandom_range(0, 31), $urandom);
        3:    push_word(c2d_pkg::CMD_RESTART, $urandom_range(0, 2047), $urandom);
        default: ;
      endcase
      push_word(c2d_pkg::CMD_SAMPLE, $urandom_range(0, 2047), rand_sample());
      n_rand++;
    end
    wait_idle();
  endtask

  function automatic int unsigned pick(int unsigned lo, int unsigned hi, int unsigned odd);
    return ($urandom_range(0, 7) == 0) ? odd : $urandom_range(lo, hi);
  endfunction

  // keep every window inside the preloaded weight range
  function automatic int unsigned fit_planes(int unsigned k, int unsigned ip,
                                             int unsigned op);
    int unsigned taps;
    taps = clampv(ip, 4) * clampv(k, 5) * clampv(k, 5);
    if (clampv(op, 16) * taps > 200) return 200 / taps;
    return op;
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      convolve_word(stim_q.pop_front());
      n_words++;
    end
    taken <= s_axis_tvalid && s_axis_tready;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (stim_q.size() != 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, stim_q[0].data, stim_q[0].idx, stim_q[0].cmd};
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 5);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      stall_tick++;
      if (!held_once && n_results >= 30) begin
        held_once = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if ((stall_tick / 200) % 2 == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 9) > 2);
      end
    end
  end

  always @(posedge clk_i) begin
    conv_out_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (window_q.size() == 0) begin
        flag_error($sformatf("unexpected result word %h", m_axis_tdata));
      end else begin
        e = window_q.pop_front();
        if (m_axis_tdata[3:0] != e.plane)
          flag_error($sformatf("plane %0d, want %0d", m_axis_tdata[3:0], e.plane));
        if (m_axis_tdata[9:4] != e.row)
          flag_error($sformatf("row %0d, want %0d", m_axis_tdata[9:4], e.row));
        if (m_axis_tdata[15:10] != e.col)
          flag_error($sformatf("col %0d, want %0d", m_axis_tdata[15:10], e.col));
        if (m_axis_tdata[47:16] != e.value)
          flag_error($sformatf("value %h, want %h", m_axis_tdata[47:16], e.value));
        if (m_axis_tlast != e.last)
          flag_error($sformatf("tlast %b, want %b", m_axis_tlast, e.last));
      end
    end
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", window_q.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] r;
    int unsigned rk, rip;
    r_height = 7'd28; r_width = 7'd28; r_kernel = 3'd3;
    r_step = 3'd1; r_inpl = 3'd1; r_outpl = 5'd16;
    row_pos = 0; col_pos = 0; plane_pos = 0; row_phase = 0; col_phase = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned i = 0; i < 200; i++) begin
      r = $urandom;
      push_word(c2d_pkg::CMD_WEIGHT, i,
                ($urandom_range(0, 3) == 0) ? r : {{20{r[11]}}, r[11:0]});
    end
    for (int unsigned i = 0; i < 16; i++) push_word(c2d_pkg::CMD_BIAS, i, $urandom);
    wait_idle();

    set_shape(3, 3, 2, 1, 1, 16);
    push_word(c2d_pkg::CMD_BIAS, 0, 32'h7fffffff);
    push_word(c2d_pkg::CMD_BIAS, 15, 32'h80000000);
    push_word(c2d_pkg::CMD_BIAS, 16, 32'h12345678);
    push_word(c2d_pkg::CMD_BIAS, 2047, 32'h0);
    push_word(c2d_pkg::CMD_WEIGHT, 2047, 32'h1000);
    push_word(c2d_pkg::CMD_WEIGHT, 1600, 32'h1000);
    push_word(c2d_pkg::CMD_WEIGHT, 0, 32'h7fffffff);
    push_word(c2d_pkg::CMD_WEIGHT, 1, 32'h80000000);
    push_word(c2d_pkg::CMD_RESTART, 0, 32'h0);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h7fffffff);
    push_word(c2d_pkg::CMD_SAMPLE, 2047, 32'h80000000);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h00007fff);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'hffff8000);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h0);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h1);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'hffffffff);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h00008000);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h00000100);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h7fffffff);
    push_word(c2d_pkg::CMD_SAMPLE, 0, 32'h7fffffff);
    wait_idle();
    set_shape(2, 2, 5, 1, 1, 16);
    push_word(c2d_pkg::CMD_RESTART, 0, 32'h0);
    for (int i = 0; i < 4; i++) push_word(c2d_pkg::CMD_SAMPLE, 0, $urandom);
    wait_idle();

    run_frames(64, 1, 1, 4, 1, 1);
    run_frames(1, 64, 1, 1, 4, 2);
    run_frames(5, 5, 5, 4, 4, 2);
    run_frames(6, 7, 2, 3, 3, 7);
    run_frames(0, 0, 0, 0, 0, 0);
    run_frames(2, 3, 7, 7, 7, 31);
    while (n_rand < 150) begin
      rk  = pick(1, 5, 7);
      rip = pick(1, 4, 7);
      run_frames(pick(1, 10, 0), pick(1, 10, 127), rk,
                 pick(1, 4, 0), rip, fit_planes(rk, rip, pick(1, 16, 31)));
    end

    while (window_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("covered %0d input words, %0d register writes, %0d windows",
             n_words, n_cfg, n_windows);
    $display("checked %0d result words, %0d errors", n_results, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
